@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the files that check their own logic.
// Both sample on clk and are switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tgpw_pkg.sv @@
package tgpw_pkg;

  // Parameter defaults
  localparam int GLYPH_COUNT_DEF    = 256;
  localparam int MAX_GLYPH_ROWS_DEF = 8;
  localparam int TAB_CHARS_DEF      = 4;
  localparam int MAX_FRAME_DIM_DEF  = 4096;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Cursor limit
  localparam logic [12:0] CURSOR_MAX = 13'h1FFF;

  // Request and character codes
  localparam logic       REQ_LOAD     = 1'b0;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_TAB     = 8'd9;

  // Configuration register indexes
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd2;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd3;
  localparam logic [2:0] REG_FORE_COLOUR  = 3'd4;
  localparam logic [2:0] REG_BACK_COLOUR  = 3'd5;

  // Configuration reset values
  localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [3:0]  GLYPH_WIDTH_RST  = 4'd8;
  localparam logic [3:0]  GLYPH_HEIGHT_RST = 4'd8;
  localparam logic [31:0] FORE_COLOUR_RST  = 32'hFFFF_FFFF;
  localparam logic [31:0] BACK_COLOUR_RST  = 32'h0000_0000;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_NEWLINE,
    CMD_TAB,
    CMD_GLYPH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       blank;
    logic [7:0] code;
    logic [2:0] row;
    logic [7:0] bits;
  } cmd_t;

  // Effective (already clamped) configuration seen by the back end
  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [3:0]  glyph_width;
    logic [3:0]  glyph_height;
    logic [31:0] fore_colour;
    logic [31:0] back_colour;
  } cfg_t;

  function automatic logic [12:0] sat_cursor(input logic [13:0] s);
    return s[13] ? CURSOR_MAX : s[12:0];
  endfunction

endpackage

@@ rtl/tgpw_front.sv @@
module tgpw_front
  import tgpw_pkg::*;
#(
  parameter int GLYPH_COUNT    = GLYPH_COUNT_DEF,
  parameter int MAX_GLYPH_ROWS = MAX_GLYPH_ROWS_DEF
) (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [7:0] char_code,
  input  logic [2:0] glyph_row,
  input  logic [7:0] row_bits,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_din
);

  logic keep;

  assign in_ready = !q_full;

  always_comb begin
    keep        = 1'b1;
    q_din.code  = char_code;
    q_din.row   = glyph_row;
    q_din.bits  = row_bits;
    q_din.blank = !(32'(char_code) < GLYPH_COUNT);
    priority if (req_type == REQ_LOAD) begin
      q_din.kind = CMD_LOAD;
      // drop loads that fall outside the glyph store
      keep = (32'(glyph_row) < MAX_GLYPH_ROWS) && (32'(char_code) < GLYPH_COUNT);
    end else if (char_code == CHAR_NEWLINE) begin
      q_din.kind = CMD_NEWLINE;
    end else if (char_code == CHAR_TAB) begin
      q_din.kind = CMD_TAB;
    end else begin
      q_din.kind = CMD_GLYPH;
    end
  end

  assign q_push = in_valid && !q_full && keep;

endmodule

@@ rtl/tgpw_queue.sv @@
module tgpw_queue
  import tgpw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;

  assign full  = (cnt == CNT_W'(QUEUE_DEPTH));
  assign empty = (cnt == '0);
  assign dout  = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      cnt <= cnt + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

@@ rtl/tgpw_back.sv @@
module tgpw_back
  import tgpw_pkg::*;
#(
  parameter int GLYPH_COUNT    = GLYPH_COUNT_DEF,
  parameter int MAX_GLYPH_ROWS = MAX_GLYPH_ROWS_DEF,
  parameter int TAB_CHARS      = TAB_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  cmd_t        cmd,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] pixel_addr,
  output logic [31:0] pixel_value,
  output logic        last
);

  localparam int DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
  localparam int IDX_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,
    S_BASE,
    S_ADDR,
    S_PIX
  } state_t;

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_widx;

  state_t      state, state_next;
  logic [12:0] cur_x, cur_x_next;
  logic [12:0] cur_y, cur_y_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic        blank, blank_next;
  logic [23:0] prod, prod_next;
  logic [23:0] rowaddr, rowaddr_next;
  logic [7:0]  rowbits, rowbits_next;
  logic [2:0]  col, col_next;
  logic [2:0]  row, row_next;
  logic        out_valid_next;
  logic [23:0] pixel_addr_next;
  logic [31:0] pixel_value_next;
  logic        last_next;
  logic        col_end;
  logic        row_end;
  logic [13:0] tab_step;

  assign tab_step = 14'(TAB_CHARS) * {10'd0, cfg.glyph_width};
  assign col_end  = ({1'b0, col} == cfg.glyph_width - 4'd1);
  assign row_end  = ({1'b0, row} == cfg.glyph_height - 4'd1);
  assign mem_widx = IDX_W'(32'(cmd.code) * MAX_GLYPH_ROWS + 32'(cmd.row));

  always_comb begin
    state_next       = state;
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    rd_idx_next      = rd_idx;
    blank_next       = blank;
    prod_next        = prod;
    rowaddr_next     = rowaddr;
    rowbits_next     = rowbits;
    col_next         = col;
    row_next         = row;
    out_valid_next   = out_valid && !out_ready;
    pixel_addr_next  = pixel_addr;
    pixel_value_next = pixel_value;
    last_next        = last;
    q_pop            = 1'b0;
    mem_we           = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (cmd.kind)
            CMD_LOAD: begin
              mem_we = 1'b1;
            end
            CMD_NEWLINE: begin
              cur_x_next = '0;
              cur_y_next = sat_cursor({1'b0, cur_y} + 14'(cfg.glyph_height));
            end
            CMD_TAB: begin
              cur_x_next = sat_cursor({1'b0, cur_x} + tab_step);
            end
            CMD_GLYPH: begin
              blank_next  = cmd.blank;
              rd_idx_next = IDX_W'(32'(cmd.code) * MAX_GLYPH_ROWS);
              if (cur_x >= cfg.frame_width) begin
                cur_x_next = '0;
                cur_y_next = sat_cursor({1'b0, cur_y} + 14'(cfg.glyph_height));
              end
              state_next = S_WRAP;
            end
            default: ;
          endcase
        end
      end
      S_WRAP: begin
        if (cur_y >= cfg.frame_height) begin
          cur_x_next = '0;
          cur_y_next = '0;
        end
        state_next = S_BASE;
      end
      S_BASE: begin
        prod_next    = 24'(cur_y) * 24'(cfg.frame_width);
        rowbits_next = blank ? 8'd0 : mem_q;
        rd_idx_next  = rd_idx + IDX_W'(1);
        col_next     = '0;
        row_next     = '0;
        if (cfg.glyph_width == 4'd0 || cfg.glyph_height == 4'd0) begin
          cur_x_next = sat_cursor({1'b0, cur_x} + 14'(cfg.glyph_width));
          state_next = S_IDLE;
        end else begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        rowaddr_next = 24'(cur_x) + prod;
        state_next   = S_PIX;
      end
      S_PIX: begin
        if (!out_valid || out_ready) begin
          out_valid_next   = 1'b1;
          pixel_addr_next  = rowaddr + 24'(col);
          pixel_value_next = rowbits[3'd7 - col] ? cfg.fore_colour : cfg.back_colour;
          last_next        = col_end && row_end;
          if (col_end) begin
            col_next     = '0;
            rowaddr_next = rowaddr + 24'(cfg.frame_width);
            rowbits_next = blank ? 8'd0 : mem_q;
            rd_idx_next  = rd_idx + IDX_W'(1);
            if (row_end) begin
              cur_x_next = sat_cursor({1'b0, cur_x} + 14'(cfg.glyph_width));
              state_next = S_IDLE;
            end else begin
              row_next = row + 3'd1;
            end
          end else begin
            col_next = col + 3'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // glyph store: loads write, the read port follows the next row address
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_widx] <= cmd.bits;
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_idx_next];
  end

  always_ff @(posedge clk) begin
    rd_idx      <= rd_idx_next;
    blank       <= blank_next;
    prod        <= prod_next;
    rowaddr     <= rowaddr_next;
    rowbits     <= rowbits_next;
    col         <= col_next;
    row         <= row_next;
    pixel_addr  <= pixel_addr_next;
    pixel_value <= pixel_value_next;
    last        <= last_next;
    if (rst) begin
      state     <= S_IDLE;
      cur_x     <= '0;
      cur_y     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_x     <= cur_x_next;
      cur_y     <= cur_y_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/text_glyph_pixel_writer.sv @@
// Text renderer with a bitmap font and a text cursor. Draw items (req_type 1)
// carry a character: newline and tab only move the cursor, any other code
// wraps the cursor if needed and produces one pixel write per glyph pixel,
// row by row, left to right, with last set on the final write; load items
// (req_type 0) fill one 8-bit row of the glyph store, bit 7 leftmost, and a
// glyph must be loaded before it is drawn. Items enter a four-entry command
// queue at one per cycle while it has room; the renderer drains it in order.
// Loads, newlines and tabs are handled as the renderer pops them; a printable
// character passes cursor wrap, row-offset multiply and base-address steps,
// then the output register gives one pixel write per cycle while the result
// sink is ready, none when either clamped glyph dimension is zero. Write
// configuration only while no item is in flight; the six registers are
// written through cfg_wen/cfg_index/cfg_wdata and indexes 6 and 7 are ignored.
`include "assert_macros.svh"

module text_glyph_pixel_writer
  import tgpw_pkg::*;
#(
  parameter int GLYPH_COUNT    = GLYPH_COUNT_DEF,
  parameter int MAX_GLYPH_ROWS = MAX_GLYPH_ROWS_DEF,
  parameter int TAB_CHARS      = TAB_CHARS_DEF,
  parameter int MAX_FRAME_DIM  = MAX_FRAME_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  char_code,
  input  logic [2:0]  glyph_row,
  input  logic [7:0]  row_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] pixel_addr,
  output logic [31:0] pixel_value,
  output logic        last
);

  localparam logic [12:0] FRAME_MAX = 13'(MAX_FRAME_DIM);
  localparam logic [3:0]  ROWS_MAX  = 4'(MAX_GLYPH_ROWS);

  // Configuration registers, as written
  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic [3:0]  glyph_width;
  logic [3:0]  glyph_height;
  logic [31:0] fore_colour;
  logic [31:0] back_colour;

  cfg_t cfg;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_din;
  cmd_t q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      glyph_width  <= GLYPH_WIDTH_RST;
      glyph_height <= GLYPH_HEIGHT_RST;
      fore_colour  <= FORE_COLOUR_RST;
      back_colour  <= BACK_COLOUR_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_wdata[12:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_wdata[12:0];
        REG_GLYPH_WIDTH:  glyph_width  <= cfg_wdata[3:0];
        REG_GLYPH_HEIGHT: glyph_height <= cfg_wdata[3:0];
        REG_FORE_COLOUR:  fore_colour  <= cfg_wdata;
        REG_BACK_COLOUR:  back_colour  <= cfg_wdata;
        default: ;  // unused indexes: drop the write
      endcase
    end
  end

  // Clamp the glyph to eight columns and the store's row count, and the frame
  // to its largest size; every cursor move and address uses the clamped values.
  always_comb begin
    cfg.frame_width  = (frame_width > FRAME_MAX) ? FRAME_MAX : frame_width;
    cfg.frame_height = (frame_height > FRAME_MAX) ? FRAME_MAX : frame_height;
    cfg.glyph_width  = (glyph_width > 4'd8) ? 4'd8 : glyph_width;
    cfg.glyph_height = (glyph_height > ROWS_MAX) ? ROWS_MAX : glyph_height;
    cfg.fore_colour  = fore_colour;
    cfg.back_colour  = back_colour;
  end

  // Front: accept and classify items, drop loads outside the store
  tgpw_front #(
    .GLYPH_COUNT    (GLYPH_COUNT),
    .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .char_code (char_code),
    .glyph_row (glyph_row),
    .row_bits  (row_bits),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  // Command queue: lets the front keep accepting while pixels drain
  tgpw_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // Back: glyph store, cursor and the pixel sequencer with its output register
  tgpw_back #(
    .GLYPH_COUNT    (GLYPH_COUNT),
    .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS),
    .TAB_CHARS      (TAB_CHARS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .cmd         (q_dout),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_addr  (pixel_addr),
    .pixel_value (pixel_value),
    .last        (last)
  );

  // The back end only takes commands that are there.
  `ASSERT_IMPL(a_pop_has_cmd, q_pop, !q_empty, "command popped from empty queue")
  // Within a glyph the next pixel is ready as soon as one is taken.
  `ASSERT_NEXT(a_pixel_stream, out_valid && out_ready && !last, out_valid,
               "gap inside a glyph's pixel stream")
  // A full queue must hold off the input side.
  `ASSERT_IMPL(a_no_overflow, q_push, !q_full, "push into full command queue")

endmodule

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tgpw_pkg::*;

  // Draw requests carry a 1 in req_type; loads use REQ_LOAD from the package.
  localparam logic        REQ_DRAW        = 1'b1;
  localparam logic [7:0]  GLYPH_A         = 8'h41;
  localparam int unsigned ROWS_PER_GLYPH  = MAX_GLYPH_ROWS_DEF;
  localparam int unsigned FRAME_DIM_MAX   = MAX_FRAME_DIM_DEF;
  localparam int unsigned TAB_STEP        = TAB_CHARS_DEF;
  localparam int unsigned GLYPH_BITS_MAX  = 8;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  // Settling time for trailing loads, newlines and tabs in the queue of four.
  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned PHASE_ITEMS     = 22;
  localparam int unsigned MAX_GAP         = 40;
  localparam int unsigned MAX_PRINTED     = 200;
  // Random traffic stops adding new glyphs once the font holds this many.
  localparam int unsigned FONT_GLYPHS     = 4;
  // Small frame for the cursor edge checks.
  localparam int unsigned SMALL_FRAME_W   = 100;
  localparam int unsigned SMALL_FRAME_H   = 40;

  typedef struct packed {
    logic [23:0] addr;
    logic [31:0] value;
    logic        last;
  } pixel_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [7:0]  char_code = '0;
  logic [2:0]  glyph_row = '0;
  logic [7:0]  row_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] pixel_addr;
  logic [31:0] pixel_value;
  logic        last;

  // Shadow of the configuration registers, as the block holds them.
  logic [12:0] cfg_frame_w = FRAME_WIDTH_RST;
  logic [12:0] cfg_frame_h = FRAME_HEIGHT_RST;
  logic [3:0]  cfg_glyph_w = GLYPH_WIDTH_RST;
  logic [3:0]  cfg_glyph_h = GLYPH_HEIGHT_RST;
  logic [31:0] cfg_fore    = FORE_COLOUR_RST;
  logic [31:0] cfg_back    = BACK_COLOUR_RST;

  // Text cursor and font contents as the block should see them.
  int unsigned cur_x = 0;
  int unsigned cur_y = 0;
  logic [7:0]  glyph_rom [0:2047];
  bit          row_written [0:2047];
  bit          glyph_listed [0:255];
  logic [7:0]  drawable_glyphs [$];

  pixel_write_t expected_writes [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off_req = 1'b0;
  int unsigned hold_left = 0;

  always #5 clk = ~clk;

  text_glyph_pixel_writer u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .char_code   (char_code),
    .glyph_row   (glyph_row),
    .row_bits    (row_bits),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_addr  (pixel_addr),
    .pixel_value (pixel_value),
    .last        (last)
  );

  function automatic int unsigned clamp(input int unsigned v, input int unsigned top);
    return (v > top) ? top : v;
  endfunction

  // Cursor moves saturate at the top of the 13-bit range.
  function automatic int unsigned cursor_add(input int unsigned a, input int unsigned b);
    return (a + b > CURSOR_MAX) ? CURSOR_MAX : a + b;
  endfunction

  function automatic logic [12:0] pick_frame_dim();
    case ($urandom_range(7))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'(FRAME_DIM_MAX);
      3:       return 13'($urandom_range(8191, FRAME_DIM_MAX + 1));
      default: return 13'($urandom_range(FRAME_DIM_MAX, 1));
    endcase
  endfunction

  // Print a bounded number of lines, but count every mismatch.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("%0t mismatch: %s", $time, msg);
  endtask

  // Update the font or the cursor for one accepted item and queue the
  // pixel writes it must produce.
  task automatic predict_pixel_writes(input logic rt, input logic [7:0] code,
                                      input logic [2:0] row, input logic [7:0] bits);
    int unsigned  gw;
    int unsigned  gh;
    int unsigned  fw;
    int unsigned  fh;
    logic [7:0]   rb;
    pixel_write_t w;
    bit           complete;
    gw = clamp(cfg_glyph_w, GLYPH_BITS_MAX);
    gh = clamp(cfg_glyph_h, ROWS_PER_GLYPH);
    fw = clamp(cfg_frame_w, FRAME_DIM_MAX);
    fh = clamp(cfg_frame_h, FRAME_DIM_MAX);
    if (rt == REQ_LOAD) begin
      glyph_rom[{code, row}] = bits;
      row_written[{code, row}] = 1'b1;
      // Track glyphs whose every row is loaded: only those may be drawn.
      complete = 1'b1;
      for (int r = 0; r < ROWS_PER_GLYPH; r++)
        if (!row_written[{code, 3'(r)}]) complete = 1'b0;
      if (complete && !glyph_listed[code]) begin
        glyph_listed[code] = 1'b1;
        drawable_glyphs.push_back(code);
      end
    end else if (code == CHAR_NEWLINE) begin
      cur_x = 0;
      cur_y = cursor_add(cur_y, gh);
    end else if (code == CHAR_TAB) begin
      cur_x = cursor_add(cur_x, TAB_STEP * gw);
    end else begin
      // Wrap past the right edge first, then back to the origin past the bottom.
      if (cur_x >= fw) begin
        cur_x = 0;
        cur_y = cursor_add(cur_y, gh);
      end
      if (cur_y >= fh) begin
        cur_x = 0;
        cur_y = 0;
      end
      for (int unsigned i = 0; i < gh; i++) begin
        rb = glyph_rom[{code, 3'(i)}];
        for (int unsigned j = 0; j < gw; j++) begin
          // No clipping; the address simply wraps at 24 bits.
          w.addr  = 24'((cur_x + j) + (cur_y + i) * fw);
          w.value = rb[7 - j] ? cfg_fore : cfg_back;
          w.last  = (i + 1 == gh) && (j + 1 == gw);
          expected_writes.push_back(w);
        end
      end
      cur_x = cursor_add(cur_x, gw);
    end
  endtask

  // Offer one item after a random idle gap and hold it until accepted.
  task automatic send_item(input logic rt, input logic [7:0] code,
                           input logic [2:0] row, input logic [7:0] bits);
    int unsigned gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < MAX_GAP)
      gap++;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    req_type  = rt;
    char_code = code;
    glyph_row = row;
    row_bits  = bits;
    do @(posedge clk); while (!in_ready);
    predict_pixel_writes(rt, code, row, bits);
  endtask

  // Row and bitmap fields mean nothing on a draw; keep them moving anyway.
  task automatic draw_char(input logic [7:0] code);
    send_item(REQ_DRAW, code, 3'($urandom), 8'($urandom));
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_index = index;
    cfg_wdata = data;
    @(negedge clk);
    cfg_wen = 1'b0;
    case (index)
      REG_FRAME_WIDTH:  cfg_frame_w = data[12:0];
      REG_FRAME_HEIGHT: cfg_frame_h = data[12:0];
      REG_GLYPH_WIDTH:  cfg_glyph_w = data[3:0];
      REG_GLYPH_HEIGHT: cfg_glyph_h = data[3:0];
      REG_FORE_COLOUR:  cfg_fore    = data;
      REG_BACK_COLOUR:  cfg_back    = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [12:0] fw, input logic [12:0] fh,
                           input logic [3:0] gw, input logic [3:0] gh,
                           input logic [31:0] fore, input logic [31:0] back);
    write_reg(REG_FRAME_WIDTH, 32'(fw));
    write_reg(REG_FRAME_HEIGHT, 32'(fh));
    write_reg(REG_GLYPH_WIDTH, 32'(gw));
    write_reg(REG_GLYPH_HEIGHT, 32'(gh));
    write_reg(REG_FORE_COLOUR, fore);
    write_reg(REG_BACK_COLOUR, back);
  endtask

  // Drop valid, drain every expected write, then let trailing control
  // items leave the command queue before anything is reconfigured.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reset configuration: load one glyph with edge patterns, then exercise
  // draw, newline and tab.
  task automatic test_default_draw();
    logic [7:0] pattern [8];
    pattern = '{8'h80, 8'h01, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'hC3, 8'h3C};
    for (int r = 0; r < ROWS_PER_GLYPH; r++)
      send_item(REQ_LOAD, GLYPH_A, 3'(r), pattern[r]);
    draw_char(GLYPH_A);
    draw_char(CHAR_NEWLINE);
    draw_char(CHAR_TAB);
    draw_char(GLYPH_A);
  endtask

  // Oversized glyph dimensions clamp to 8; a zero height draws nothing but
  // still moves the cursor, and a zero width draws nothing.
  task automatic test_glyph_sizes();
    wait_idle();
    configure(13'd640, 13'd480, 4'd9, 4'd12, 32'h1234_5678, 32'h9ABC_DEF0);
    draw_char(GLYPH_A);
    wait_idle();
    configure(13'd640, 13'd480, 4'd15, 4'd0, cfg_fore, cfg_back);
    draw_char(GLYPH_A);
    wait_idle();
    configure(13'd640, 13'd480, 4'd0, 4'd3, cfg_fore, cfg_back);
    draw_char(GLYPH_A);
    wait_idle();
    configure(13'd640, 13'd480, 4'd3, 4'd5, 32'h0000_0000, 32'hFFFF_FFFF);
    draw_char(GLYPH_A);
    draw_char(GLYPH_A);
  endtask

  // Zero width wraps every character; oversized width saturates; a short
  // frame sends the cursor home; a narrow frame lets writes spill unclipped.
  task automatic test_frame_wrap();
    wait_idle();
    configure(13'd0, 13'd4096, 4'd8, 4'd8, cfg_fore, cfg_back);
    draw_char(GLYPH_A);
    draw_char(GLYPH_A);
    wait_idle();
    configure(13'd8191, 13'd1, 4'd8, 4'd8, cfg_fore, cfg_back);
    draw_char(GLYPH_A);
    draw_char(CHAR_NEWLINE);
    draw_char(GLYPH_A);
    wait_idle();
    configure(13'd10, 13'd480, 4'd8, 4'd8, cfg_fore, cfg_back);
    draw_char(CHAR_NEWLINE);
    draw_char(GLYPH_A);
    draw_char(GLYPH_A);
  endtask

  // Run newlines off the bottom of a short frame so the next character goes
  // home; draw a seven-row glyph on the last text line so it spills below the
  // frame; tab past the right edge so one character wraps both ways at once.
  task automatic test_cursor_limits();
    wait_idle();
    configure(13'(SMALL_FRAME_W), 13'(SMALL_FRAME_H), 4'd8, 4'd7,
              32'hA5A5_0F0F, 32'h5A5A_F0F0);
    draw_char(CHAR_NEWLINE);
    while (cur_y < SMALL_FRAME_H) draw_char(CHAR_NEWLINE);
    draw_char(GLYPH_A);
    while (cur_y + 7 < SMALL_FRAME_H) draw_char(CHAR_NEWLINE);
    draw_char(GLYPH_A);
    while (cur_x < SMALL_FRAME_W) draw_char(CHAR_TAB);
    draw_char(GLYPH_A);
    draw_char(GLYPH_A);
  endtask

  // Hold the result side off for a long stretch while items keep coming,
  // so the command queue fills and in_ready drops.
  task automatic test_backpressure();
    wait_idle();
    configure(13'd640, 13'd480, 4'd8, 4'd8, $urandom, $urandom);
    hold_off_req = 1'b1;
    repeat (16) draw_char(GLYPH_A);
    wait_idle();
  endtask

  task automatic random_config();
    logic [3:0] gw;
    logic [3:0] gh;
    gw = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(8, 1));
    gh = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(8, 1));
    configure(pick_frame_dim(), pick_frame_dim(), gw, gh, $urandom, $urandom);
  endtask

  // Mostly printable characters from loaded glyphs; a new glyph gets its
  // missing rows loaded first, until the font is big enough. Stray loads and
  // cursor controls fill the rest.
  task automatic random_item();
    int unsigned pick;
    logic [7:0]  code;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_item(REQ_LOAD, 8'($urandom), 3'($urandom), 8'($urandom));
    end else if (pick < 23) begin
      draw_char(CHAR_NEWLINE);
    end else if (pick < 31) begin
      draw_char(CHAR_TAB);
    end else begin
      if (drawable_glyphs.size() != 0 &&
          (drawable_glyphs.size() >= FONT_GLYPHS || $urandom_range(3) != 0))
        code = drawable_glyphs[$urandom_range(drawable_glyphs.size() - 1)];
      else
        code = 8'($urandom);
      if (code != CHAR_NEWLINE && code != CHAR_TAB)
        for (int r = 0; r < ROWS_PER_GLYPH; r++)
          if (!row_written[{code, 3'(r)}])
            send_item(REQ_LOAD, code, 3'(r), 8'($urandom));
      draw_char(code);
    end
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
    wait_idle();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (2) begin
      random_config();
      repeat (PHASE_ITEMS) random_item();
      wait_idle();
    end
  endtask

  // Result side: honor a hold-off request first, else stall at random.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare every accepted pixel write with the oldest expected one.
  always @(posedge clk) begin : check_pixel_writes
    pixel_write_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel write addr %h value %h",
                                  pixel_addr, pixel_value));
      end else begin
        want = expected_writes.pop_front();
        if (pixel_addr !== want.addr)
          report_mismatch($sformatf("pixel_addr got %h want %h", pixel_addr, want.addr));
        if (pixel_value !== want.value)
          report_mismatch($sformatf("pixel_value got %h want %h at addr %h",
                                    pixel_value, want.value, want.addr));
        if (last !== want.last)
          report_mismatch($sformatf("last got %b want %b at addr %h",
                                    last, want.last, want.addr));
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_draw();
    test_glyph_sizes();
    test_frame_wrap();
    test_cursor_limits();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(81, 0);
    test_random_traffic(0, 81);
    test_random_traffic(21, 21);

    wait_idle();
    if (expected_writes.size() != 0)
      report_mismatch($sformatf("%0d pixel writes never arrived", expected_writes.size()));
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
